### rtl/tlvtc_pkg.sv
// Package for the TLV tag checker: allowed tag spans and the tag check.
package tlvtc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned TagW    = 16;
  localparam int unsigned NumSpan = 18;
  localparam int unsigned OutW    = 24;  // 18 used bits, padded to whole bytes

  typedef struct packed {
    logic [TagW-1:0] lo;
    logic [TagW-1:0] hi;
  } tag_span_t;

  typedef tag_span_t [NumSpan-1:0] span_tbl_t;

  // Allowed SMPP optional-parameter tag ranges, inclusive at both ends.
  localparam span_tbl_t AllowedSpans = '{
    '{lo: 16'h1383, hi: 16'h1383},
    '{lo: 16'h1380, hi: 16'h1380},
    '{lo: 16'h130C, hi: 16'h130C},
    '{lo: 16'h1203, hi: 16'h1204},
    '{lo: 16'h1201, hi: 16'h1201},
    '{lo: 16'h0600, hi: 16'h0613},
    '{lo: 16'h0501, hi: 16'h0501},
    '{lo: 16'h0420, hi: 16'h0428},
    '{lo: 16'h0381, hi: 16'h0381},
    '{lo: 16'h0302, hi: 16'h0304},
    '{lo: 16'h020A, hi: 16'h0210},
    '{lo: 16'h0201, hi: 16'h0205},
    '{lo: 16'h0030, hi: 16'h0030},
    '{lo: 16'h001D, hi: 16'h001E},
    '{lo: 16'h0019, hi: 16'h0019},
    '{lo: 16'h0017, hi: 16'h0017},
    '{lo: 16'h000D, hi: 16'h0010},
    '{lo: 16'h0005, hi: 16'h0008}
  };

  // Independent range compares, OR-reduced.
  function automatic logic tag_allowed(input logic [TagW-1:0] tag);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NumSpan; k++) begin
      if ((tag >= AllowedSpans[k].lo) && (tag <= AllowedSpans[k].hi)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

### rtl/tlv_stream_tag_checker.sv
// TLV stream tag checker: parses tag-length-value records and reports tag validity.
//
//  channel  | dir | tdata (low bit up)                                  | tlast
//  ---------+-----+-----------------------------------------------------+-----------
//  s_axis   | in  | [7:0] byte_value                                    | last_byte
//  m_axis   | out | [0] all_tags_valid, [16:1] first_bad_tag,           | -
//           |     | [17] header_truncated, [23:18] zero                 |
//
// One byte per cycle sustained: a beat sits in the input register, one
// range-compare stage updates the parser, and a last beat's verdict is written to
// the result register as that beat leaves the input register.
// Only a last beat can wait in the input register, while an earlier verdict
// is held and not taken; input ready stays low until it moves on.
// rst_ni clears parser phase, error flag and both valid flags asynchronously.
module tlv_stream_tag_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [tlvtc_pkg::ByteW-1:0] s_axis_tdata_i,  // [7:0] byte_value
  input  logic                      s_axis_tlast_i,    // last_byte
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [tlvtc_pkg::OutW-1:0] m_axis_tdata_o    // all_tags_valid, first_bad_tag,
                                                       // header_truncated, pad
);

  typedef enum logic [2:0] {
    PH_TAG_HI = 3'd0,
    PH_TAG_LO = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_SKIP   = 3'd4
  } phase_e;

  // Input register
  logic                        in_valid_q;
  logic [tlvtc_pkg::ByteW-1:0] in_byte_q;
  logic                        in_last_q;

  // Parser state
  phase_e                      phase_q, phase_d;
  logic [tlvtc_pkg::TagW-1:0]  tag_q, tag_d;
  logic [tlvtc_pkg::ByteW-1:0] len_hi_q, len_hi_d;
  logic [tlvtc_pkg::TagW-1:0]  skip_q, skip_d;
  logic                        error_q, error_d;
  logic [tlvtc_pkg::TagW-1:0]  bad_q, bad_d;

  // Result register
  logic                        out_valid_q;
  logic [tlvtc_pkg::OutW-1:0]  out_data_q, out_data_d;

  logic advance;
  logic truncated;
  logic [tlvtc_pkg::TagW-1:0] len_full;
  logic skip_next_zero;

  // A buffered beat moves on unless it is a last beat blocked by an untaken verdict.
  assign advance         = in_valid_q & (~in_last_q | ~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign len_full       = {len_hi_q, in_byte_q};
  assign skip_next_zero = (skip_q == tlvtc_pkg::TagW'(1));

  always_comb begin
    phase_d  = phase_q;
    tag_d    = tag_q;
    len_hi_d = len_hi_q;
    skip_d   = skip_q;
    error_d  = error_q;
    bad_d    = bad_q;
    case (phase_q)
      PH_TAG_LO: begin
        tag_d   = {tag_q[tlvtc_pkg::TagW-1:tlvtc_pkg::ByteW], in_byte_q};
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_hi_d = in_byte_q;
        phase_d  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        // length complete: check the tag, keep only the first offender
        if (!tlvtc_pkg::tag_allowed(tag_q) && !error_q) begin
          error_d = 1'b1;
          bad_d   = tag_q;
        end
        skip_d  = len_full;
        phase_d = (len_full == '0) ? PH_TAG_HI : PH_SKIP;
      end
      PH_SKIP: begin
        skip_d = skip_q - tlvtc_pkg::TagW'(1);
        if (skip_next_zero) begin
          phase_d = PH_TAG_HI;
        end
      end
      default: begin
        tag_d   = {in_byte_q, tlvtc_pkg::ByteW'(0)};
        phase_d = PH_TAG_LO;
      end
    endcase
  end

  assign truncated = (phase_d == PH_TAG_LO) || (phase_d == PH_LEN_HI) ||
                     (phase_d == PH_LEN_LO);

  always_comb begin
    out_data_d        = '0;
    out_data_d[0]     = ~error_d;
    out_data_d[16:1]  = error_d ? bad_d : '0;
    out_data_d[17]    = truncated;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_TAG_HI;
      error_q     <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        // a last beat returns the parser to its start state
        phase_q <= in_last_q ? PH_TAG_HI : phase_d;
        error_q <= in_last_q ? 1'b0 : error_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance) begin
      tag_q    <= tag_d;
      len_hi_q <= len_hi_d;
      skip_q   <= skip_d;
      bad_q    <= bad_d;
    end
    if (advance && in_last_q) begin
      out_data_q <= out_data_d;
    end
  end

`ifndef SYNTHESIS
  // skip phase is only ever entered with bytes left to skip
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (skip_q != '0))
    else $error("skip phase with zero count");

  // a verdict of all-valid never carries a bad tag
  a_clean_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> (m_axis_tdata_o[16:1] == '0))
    else $error("valid verdict with nonzero bad tag");

  // parser restarts after every last beat
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> ((phase_q == PH_TAG_HI) && !error_q && out_valid_q))
    else $error("parser not restarted after last beat");

  // a held beat is not dropped
  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_last_q)))
    else $error("stalled input beat lost");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the TLV stream tag checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ByteTarget = 1550;
  localparam int unsigned HoldCycles = 400;

  typedef enum logic [2:0] {
    TAG_HI,
    TAG_LO,
    LEN_HI,
    LEN_LO,
    SKIP_VAL
  } parse_phase_e;

  typedef struct packed {
    logic        all_ok;
    logic [15:0] bad_tag;
    logic        cut_short;
  } verdict_t;

  // Allowed tag spans as {lo, hi}, inclusive at both ends.
  function automatic logic [31:0] span_bounds(input int idx);
    case (idx)
      0:       return {16'h0005, 16'h0008};
      1:       return {16'h000D, 16'h0010};
      2:       return {16'h0017, 16'h0017};
      3:       return {16'h0019, 16'h0019};
      4:       return {16'h001D, 16'h001E};
      5:       return {16'h0030, 16'h0030};
      6:       return {16'h0201, 16'h0205};
      7:       return {16'h020A, 16'h0210};
      8:       return {16'h0302, 16'h0304};
      9:       return {16'h0381, 16'h0381};
      10:      return {16'h0420, 16'h0428};
      11:      return {16'h0501, 16'h0501};
      12:      return {16'h0600, 16'h0613};
      13:      return {16'h1201, 16'h1201};
      14:      return {16'h1203, 16'h1204};
      15:      return {16'h130C, 16'h130C};
      16:      return {16'h1380, 16'h1380};
      default: return {16'h1383, 16'h1383};
    endcase
  endfunction

  // Parser model plus the queue of verdicts still owed by the block.
  class verdict_board;
    parse_phase_e phase;
    logic [15:0]  tag_acc;
    logic [7:0]   len_hi;
    logic [15:0]  skip_left;
    logic         err_seen;
    logic [15:0]  bad_tag;
    verdict_t     pending[$];
    int           errors;

    function new();
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      phase     = TAG_HI;
      tag_acc   = '0;
      len_hi    = '0;
      skip_left = '0;
      err_seen  = 1'b0;
      bad_tag   = '0;
    endfunction

    function bit tag_ok(input logic [15:0] t);
      logic [31:0] sp;
      for (int k = 0; k < tlvtc_pkg::NumSpan; k++) begin
        sp = span_bounds(k);
        if (t >= sp[31:16] && t <= sp[15:0]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_byte(input logic [7:0] b, input logic last);
      logic [15:0] rec_len;
      verdict_t    v;
      case (phase)
        TAG_LO: begin
          tag_acc[7:0] = b;
          phase = LEN_HI;
        end
        LEN_HI: begin
          len_hi = b;
          phase = LEN_LO;
        end
        LEN_LO: begin
          rec_len = {len_hi, b};
          // only the first disallowed tag of a stream is kept
          if (!tag_ok(tag_acc) && !err_seen) begin
            err_seen = 1'b1;
            bad_tag  = tag_acc;
          end
          skip_left = rec_len;
          phase = (rec_len == 16'd0) ? TAG_HI : SKIP_VAL;
        end
        SKIP_VAL: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) phase = TAG_HI;
        end
        default: begin
          tag_acc = {b, 8'h00};
          phase = TAG_LO;
        end
      endcase
      if (last) begin
        v.all_ok    = !err_seen;
        v.bad_tag   = err_seen ? bad_tag : 16'h0000;
        v.cut_short = (phase == TAG_LO || phase == LEN_HI || phase == LEN_LO);
        pending.push_back(v);
        clear_stream();
      end
    endfunction

    function void compare_field(input string name, input int want, input int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(input logic [23:0] d);
      verdict_t v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected verdict beat, expected none, actual 0x%06h", $time, d);
        errors++;
        return;
      end
      v = pending.pop_front();
      compare_field("all_tags_valid", int'(v.all_ok), int'(d[0]));
      compare_field("first_bad_tag", int'(v.bad_tag), int'(d[16:1]));
      compare_field("header_truncated", int'(v.cut_short), int'(d[17]));
      compare_field("pad", 0, int'(d[23:18]));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;  // [7:0] byte_value
  logic        s_axis_tlast_i = 1'b0;  // last_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;  // [0] all_tags_valid, [16:1] first_bad_tag,
                                // [17] header_truncated, [23:18] pad

  verdict_board board;
  logic [7:0]   frame_q[$];
  int unsigned  bytes_sent = 0;
  int unsigned  burst_left = 0;
  int unsigned  cycle_count = 0;

  tlv_stream_tag_checker i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the block locks up.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Verdict beats are checked as they are taken.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_verdict(m_axis_tdata_o);
  end

  // Sender: called at a falling edge, returns at the falling edge after the beat is taken.
  // Bursts of random length, with a random gap (sometimes none) ahead of each.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_byte(b, last);
    bytes_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  // Tags inside a span, some just outside a span edge, some anywhere.
  function automatic logic [15:0] pick_tag();
    logic [31:0] sp;
    sp = span_bounds($urandom_range(0, tlvtc_pkg::NumSpan - 1));
    case ($urandom_range(0, 4))
      0, 1:    return 16'($urandom_range(sp[15:0], sp[31:16]));
      2:       return sp[31:16] - 16'd1;
      3:       return sp[15:0] + 16'd1;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Well-formed records with random content; the frame may end inside a
  // value field or inside a trailing header.
  task automatic build_record_frame();
    int unsigned n_rec;
    int unsigned n_val;
    logic [15:0] tag;
    logic [15:0] len;
    bit          cut;
    n_rec = $urandom_range(1, 4);
    cut = 1'b0;
    for (int r = 0; r < n_rec && !cut; r++) begin
      tag = pick_tag();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: len = 16'($urandom_range(0, 4));
        5, 6, 7:       len = 16'($urandom_range(5, 20));
        default:       len = 16'($urandom_range(0, 16'hFFFF));
      endcase
      n_val = 32'(len);
      if (len > 20) begin
        n_val = $urandom_range(0, 8);
        cut = 1'b1;
      end else if (len != 0 && $urandom_range(0, 7) == 0) begin
        n_val = $urandom_range(0, 32'(len) - 1);
        cut = 1'b1;
      end
      frame_q.push_back(tag[15:8]);
      frame_q.push_back(tag[7:0]);
      frame_q.push_back(len[15:8]);
      frame_q.push_back(len[7:0]);
      repeat (n_val) frame_q.push_back(8'($urandom_range(0, 255)));
    end
    if (!cut && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver: ready pattern changes mode after each random-length span; one long
  // hold-off part way through lets the verdict register fill and stall input.
  initial begin
    int unsigned mode;
    int unsigned span_len;
    bit          held;
    held = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && bytes_sent >= 600) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        span_len = $urandom_range(20, 120);
        for (int c = 0; c < span_len; c++) begin
          case (mode)
            0:       m_axis_tready_i <= 1'b1;
            1:       m_axis_tready_i <= c[0];
            2:       m_axis_tready_i <= 1'($urandom_range(0, 1));
            default: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
          endcase
          @(negedge clk_i);
        end
      end
    end
  end

  initial begin
    board = new();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: header cut after one, two and three bytes.
    frame_q = '{8'h00};
    send_frame();
    frame_q = '{8'h00, 8'h05};
    send_frame();
    frame_q = '{8'h13, 8'h83, 8'h00};
    send_frame();
    // Disallowed tag just below the lowest span, then an allowed one; zero lengths.
    frame_q = '{8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00};
    send_frame();
    // All-ones tag and length, stream ends inside the value bytes.
    frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAB};
    send_frame();
    // Top of a span, one value byte, record complete.
    frame_q = '{8'h04, 8'h28, 8'h00, 8'h01, 8'h5A};
    send_frame();

    // Random: mostly well-formed records, some raw noise.
    while (bytes_sent < ByteTarget) begin
      if ($urandom_range(0, 99) < 85) begin
        build_record_frame();
      end else begin
        repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
      end
      send_frame();
    end
    s_axis_tvalid_i <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
